// ===== sv/cswd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cswd_pkg;

  // Ring and history sizes (powers of two)
  localparam int RAW_AW       = 6;
  localparam int RAW_DEPTH    = 1 << RAW_AW;
  localparam int HIST_AW      = 4;
  localparam int HIST_DEPTH   = 1 << HIST_AW;

  // Field widths
  localparam int SAMPLE_W     = 16;
  localparam int NUM_CH       = 4;
  localparam int RING_W       = NUM_CH * SAMPLE_W;
  localparam int SUM_W        = SAMPLE_W + RAW_AW + 1;
  localparam int POS_W        = 18;
  localparam int DIFF_W       = POS_W + 1;
  localparam int RATE_W       = 32;
  localparam int MOTION_W     = 2;
  localparam int INTERVAL_W   = 4;
  localparam int SCALE_W      = 10;
  localparam int THR_W        = 15;
  localparam int PROD_W       = DIFF_W + SCALE_W + 1;

  // Configuration port
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(1);
  localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(20);
  localparam logic [THR_W-1:0]      THR_X_RST    = THR_W'(32000);
  localparam logic [THR_W-1:0]      THR_Y_RST    = THR_W'(30000);

  // Register map
  typedef enum logic [1:0] {
    REG_DERIV_INTERVAL = 2'd0,
    REG_RATE_SCALE     = 2'd1,
    REG_THRESHOLD_X    = 2'd2,
    REG_THRESHOLD_Y    = 2'd3
  } reg_idx_t;

  // Action codes
  localparam logic ACTION_SAMPLE    = 1'b0;
  localparam logic ACTION_CALIBRATE = 1'b1;

  // Channel slots within a ring entry
  localparam int CH_BOTTOM = 0;
  localparam int CH_LEFT   = 1;
  localparam int CH_RIGHT  = 2;
  localparam int CH_TOP    = 3;

  // Motion codes
  localparam logic signed [MOTION_W-1:0] MOTION_POS  = 2'sb01;
  localparam logic signed [MOTION_W-1:0] MOTION_NONE = 2'sb00;
  localparam logic signed [MOTION_W-1:0] MOTION_NEG  = 2'sb11;

endpackage
`default_nettype wire

// ===== sv/cswd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cswd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/capacitive_swipe_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A sample word reaches the result port via stages 1, 2, 3 and the output register.
// Throughput: one word per cycle unless the output stalls; the raw ring read is
//   issued at acceptance so ring update, sums and history finish as stage 1 advances.
// Calibrate words leave stage 1 even while later stages stall; they produce no result.
// Reset (rst, synchronous) clears ring valid bits, sums, baselines, history, slots,
//   the pipeline, and returns the configuration registers to their defaults.
module capacitive_swipe_detector (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // Configuration port
  input  wire logic                                      psel,
  input  wire logic                                      penable,
  input  wire logic                                      pwrite,
  input  wire logic [cswd_pkg::PADDR_W-1:0]              paddr,
  input  wire logic [cswd_pkg::PDATA_W-1:0]              pwdata,
  output logic      [cswd_pkg::PDATA_W-1:0]              prdata,
  output logic                                           pready,
  // Input channel
  input  wire logic                                      item_valid,
  output logic                                           item_ready,
  input  wire logic                                      action,
  input  wire logic signed [cswd_pkg::SAMPLE_W-1:0]      sample_bottom,
  input  wire logic signed [cswd_pkg::SAMPLE_W-1:0]      sample_left,
  input  wire logic signed [cswd_pkg::SAMPLE_W-1:0]      sample_right,
  input  wire logic signed [cswd_pkg::SAMPLE_W-1:0]      sample_top,
  // Result channel
  output logic                                           result_valid,
  input  wire logic                                      result_ready,
  output logic signed [cswd_pkg::POS_W-1:0]              position_x,
  output logic signed [cswd_pkg::POS_W-1:0]              position_y,
  output logic signed [cswd_pkg::RATE_W-1:0]             rate_x,
  output logic signed [cswd_pkg::RATE_W-1:0]             rate_y,
  output logic signed [cswd_pkg::MOTION_W-1:0]           motion_x,
  output logic signed [cswd_pkg::MOTION_W-1:0]           motion_y
);

  localparam int SW = cswd_pkg::SAMPLE_W;
  localparam int NC = cswd_pkg::NUM_CH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [cswd_pkg::INTERVAL_W-1:0] deriv_interval;
  logic [cswd_pkg::SCALE_W-1:0]    rate_scale;
  logic [cswd_pkg::THR_W-1:0]      threshold_x;
  logic [cswd_pkg::THR_W-1:0]      threshold_y;
  cswd_pkg::reg_idx_t              reg_idx;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = cswd_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      deriv_interval <= cswd_pkg::INTERVAL_RST;
      rate_scale     <= cswd_pkg::SCALE_RST;
      threshold_x    <= cswd_pkg::THR_X_RST;
      threshold_y    <= cswd_pkg::THR_Y_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        cswd_pkg::REG_DERIV_INTERVAL: deriv_interval <= pwdata[cswd_pkg::INTERVAL_W-1:0];
        cswd_pkg::REG_RATE_SCALE:     rate_scale     <= pwdata[cswd_pkg::SCALE_W-1:0];
        cswd_pkg::REG_THRESHOLD_X:    threshold_x    <= pwdata[cswd_pkg::THR_W-1:0];
        cswd_pkg::REG_THRESHOLD_Y:    threshold_y    <= pwdata[cswd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      cswd_pkg::REG_DERIV_INTERVAL: prdata = cswd_pkg::PDATA_W'(deriv_interval);
      cswd_pkg::REG_RATE_SCALE:     prdata = cswd_pkg::PDATA_W'(rate_scale);
      cswd_pkg::REG_THRESHOLD_X:    prdata = cswd_pkg::PDATA_W'(threshold_x);
      cswd_pkg::REG_THRESHOLD_Y:    prdata = cswd_pkg::PDATA_W'(threshold_y);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  logic v1, v2, v3;
  logic s1_action;
  logic in_accept, o_free, s3_free, s2_free, s1_go, s1_free;
  logic s1_sample_go, s1_cal_go;

  assign o_free       = !result_valid || result_ready;
  assign s3_free      = !v3 || o_free;
  assign s2_free      = !v2 || s3_free;
  assign s1_go        = v1 && ((s1_action == cswd_pkg::ACTION_CALIBRATE) || s2_free);
  assign s1_free      = !v1 || s1_go;
  assign item_ready   = s1_free;
  assign in_accept    = item_valid && item_ready;
  assign s1_sample_go = s1_go && (s1_action == cswd_pkg::ACTION_SAMPLE);
  assign s1_cal_go    = s1_go && (s1_action == cswd_pkg::ACTION_CALIBRATE);

  // ---------------------------------------------------------------------------
  // Raw ring: prefetch the slot a sample word will overwrite
  logic [cswd_pkg::RAW_AW-1:0]    wslot;
  logic [cswd_pkg::RAW_AW-1:0]    rd_slot;
  logic [cswd_pkg::RAW_AW-1:0]    s1_slot;
  logic [cswd_pkg::RAW_DEPTH-1:0] raw_valid;
  logic                           s1_old_valid;
  logic                           ring_re;
  logic [cswd_pkg::RING_W-1:0]    ring_rdata;
  logic [cswd_pkg::RING_W-1:0]    ring_wdata;
  logic signed [SW-1:0]           s1_smp [NC];

  assign rd_slot = wslot + cswd_pkg::RAW_AW'(1);
  assign ring_re = in_accept && (action == cswd_pkg::ACTION_SAMPLE);
  assign ring_wdata = {s1_smp[cswd_pkg::CH_TOP], s1_smp[cswd_pkg::CH_RIGHT],
                       s1_smp[cswd_pkg::CH_LEFT], s1_smp[cswd_pkg::CH_BOTTOM]};

  cswd_ram #(
    .WIDTH (cswd_pkg::RING_W),
    .DEPTH (cswd_pkg::RAW_DEPTH)
  ) u_raw_ring (
    .clk   (clk),
    .we    (s1_sample_go),
    .waddr (s1_slot),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (rd_slot),
    .rdata (ring_rdata)
  );

  // Stage 1: capture the word, advance the write slot, track written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      wslot     <= '0;
      raw_valid <= '0;
    end else begin
      if (s1_free) begin
        v1 <= in_accept;
      end
      if (ring_re) begin
        wslot <= rd_slot;
      end
      if (s1_sample_go) begin
        raw_valid[s1_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action                  <= action;
      s1_slot                    <= rd_slot;
      s1_old_valid               <= raw_valid[rd_slot];
      s1_smp[cswd_pkg::CH_BOTTOM] <= sample_bottom;
      s1_smp[cswd_pkg::CH_LEFT]   <= sample_left;
      s1_smp[cswd_pkg::CH_RIGHT]  <= sample_right;
      s1_smp[cswd_pkg::CH_TOP]    <= sample_top;
    end
  end

  // ---------------------------------------------------------------------------
  // Running sums and baselines
  logic signed [cswd_pkg::SUM_W-1:0] sums      [NC];
  logic signed [cswd_pkg::SUM_W-1:0] sums_next [NC];
  logic signed [cswd_pkg::SUM_W-1:0] sum_adj   [NC];
  logic signed [SW-1:0]              baselines [NC];
  logic signed [SW-1:0]              base_next [NC];
  logic signed [SW-1:0]              old_smp   [NC];

  // Swap the overwritten sample for the new one; average toward zero
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      old_smp[c]   = s1_old_valid ? $signed(ring_rdata[c*SW +: SW]) : '0;
      sums_next[c] = sums[c] - cswd_pkg::SUM_W'(old_smp[c])
                             + cswd_pkg::SUM_W'(s1_smp[c]);
      sum_adj[c]   = sums[c] + (sums[c][cswd_pkg::SUM_W-1] ?
                     cswd_pkg::SUM_W'(cswd_pkg::RAW_DEPTH - 1) : cswd_pkg::SUM_W'(0));
      base_next[c] = SW'(sum_adj[c] >>> cswd_pkg::RAW_AW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        sums[c]      <= '0;
        baselines[c] <= '0;
      end
    end else begin
      if (s1_sample_go) begin
        sums <= sums_next;
      end
      if (s1_cal_go) begin
        baselines <= base_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Position, history and look-back difference
  logic signed [SW:0]                  corr [NC];
  logic signed [cswd_pkg::POS_W-1:0]   px, py;
  logic signed [cswd_pkg::POS_W-1:0]   hist_x [cswd_pkg::HIST_DEPTH];
  logic signed [cswd_pkg::POS_W-1:0]   hist_y [cswd_pkg::HIST_DEPTH];
  logic [cswd_pkg::HIST_AW-1:0]        hslot, hslot_new, back;
  logic [cswd_pkg::HIST_AW-1:0]        interval_mod;
  logic signed [cswd_pkg::DIFF_W-1:0]  dx, dy;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      corr[c] = (SW+1)'(s1_smp[c]) - (SW+1)'(baselines[c]);
    end
    px = cswd_pkg::POS_W'(corr[cswd_pkg::CH_RIGHT]) - cswd_pkg::POS_W'(corr[cswd_pkg::CH_LEFT]);
    py = cswd_pkg::POS_W'(corr[cswd_pkg::CH_TOP]) - cswd_pkg::POS_W'(corr[cswd_pkg::CH_BOTTOM]);
    hslot_new     = hslot + cswd_pkg::HIST_AW'(1);
    interval_mod  = cswd_pkg::HIST_AW'(deriv_interval);
    back          = hslot_new - interval_mod;
    // A zero look-back compares the newest position with itself
    if (interval_mod == '0) begin
      dx = '0;
      dy = '0;
    end else begin
      dx = cswd_pkg::DIFF_W'(px) - cswd_pkg::DIFF_W'(hist_x[back]);
      dy = cswd_pkg::DIFF_W'(py) - cswd_pkg::DIFF_W'(hist_y[back]);
    end
  end

  // Store the new position
  always_ff @(posedge clk) begin
    if (rst) begin
      hslot <= '0;
      for (int i = 0; i < cswd_pkg::HIST_DEPTH; i++) begin
        hist_x[i] <= '0;
        hist_y[i] <= '0;
      end
    end else if (s1_sample_go) begin
      hslot             <= hslot_new;
      hist_x[hslot_new] <= px;
      hist_y[hslot_new] <= py;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: position and difference
  logic signed [cswd_pkg::POS_W-1:0]  s2_px, s2_py;
  logic signed [cswd_pkg::DIFF_W-1:0] s2_dx, s2_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= s1_sample_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_px <= px;
      s2_py <= py;
      s2_dx <= dx;
      s2_dy <= dy;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale the difference; the 30-bit product stays inside 32 bits,
  // so widening it to the rate width loses nothing
  logic signed [cswd_pkg::PROD_W-1:0] prod_x, prod_y;
  logic signed [cswd_pkg::SCALE_W:0]  scale_s;
  logic signed [cswd_pkg::POS_W-1:0]  s3_px, s3_py;
  logic signed [cswd_pkg::RATE_W-1:0] s3_rx, s3_ry;

  assign scale_s = $signed({1'b0, rate_scale});
  assign prod_x  = s2_dx * scale_s;
  assign prod_y  = s2_dy * scale_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_free) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_px <= s2_px;
      s3_py <= s2_py;
      s3_rx <= cswd_pkg::RATE_W'(prod_x);
      s3_ry <= cswd_pkg::RATE_W'(prod_y);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: classify each axis against its threshold
  logic signed [cswd_pkg::RATE_W-1:0]   thr_x_s, thr_y_s;
  logic signed [cswd_pkg::MOTION_W-1:0] mx, my;

  assign thr_x_s = $signed(cswd_pkg::RATE_W'(threshold_x));
  assign thr_y_s = $signed(cswd_pkg::RATE_W'(threshold_y));

  always_comb begin
    if (s3_rx > thr_x_s) begin
      mx = cswd_pkg::MOTION_POS;
    end else if (s3_rx < -thr_x_s) begin
      mx = cswd_pkg::MOTION_NEG;
    end else begin
      mx = cswd_pkg::MOTION_NONE;
    end
    if (s3_ry > thr_y_s) begin
      my = cswd_pkg::MOTION_POS;
    end else if (s3_ry < -thr_y_s) begin
      my = cswd_pkg::MOTION_NEG;
    end else begin
      my = cswd_pkg::MOTION_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (o_free) begin
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      position_x <= s3_px;
      position_y <= s3_py;
      rate_x     <= s3_rx;
      rate_y     <= s3_ry;
      motion_x   <= mx;
      motion_y   <= my;
    end
  end

`ifndef SYNTHESIS
  // Ring prefetch never reads the slot being written in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (s1_sample_go && ring_re) |-> (rd_slot != s1_slot))
    else $error("raw ring read and write collide");

  // A full pipeline holding a sample word with a stalled result port refuses new words
  assert property (@(posedge clk) disable iff (rst)
    (v1 && (s1_action == cswd_pkg::ACTION_SAMPLE) && v2 && v3 && result_valid &&
     !result_ready) |-> !item_ready)
    else $error("word accepted into a full pipeline");

  // A valid result never carries the unused motion code
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((motion_x != 2'sb10) && (motion_y != 2'sb10)))
    else $error("invalid motion code on result");

  // Reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> (!result_valid && !v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire
